// ----- design/pivl_pkg.sv -----
// Shared types, constants and the control store of the PI velocity loop.
package pivl_pkg;

  localparam int unsigned INTEGRATOR_WIDTH_DEF = 48;
  // Shared multiplier: 25 bit signed by 17 bit signed.
  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  // Fraction bits of the integrator and of the P term.
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned STEP_W  = 4;

  localparam logic [2:0] REG_PGAIN  = 3'd0;
  localparam logic [2:0] REG_IGAIN  = 3'd1;
  localparam logic [2:0] REG_WGAIN  = 3'd2;
  localparam logic [2:0] REG_VSCALE = 3'd3;
  localparam logic [2:0] REG_UPPER  = 3'd4;
  localparam logic [2:0] REG_LOWER  = 3'd5;

  localparam logic [23:0] PGAIN_RST  = 24'd175828;
  localparam logic [15:0] IGAIN_RST  = 16'd16302;
  localparam logic [15:0] WGAIN_RST  = 16'd6076;
  localparam logic [15:0] VSCALE_RST = 16'd5156;
  localparam logic [7:0]  UPPER_RST  = 8'd100;
  localparam logic [8:0]  LOWER_RST  = 9'h19C;

  // Microcode step addresses.
  localparam logic [STEP_W-1:0] STEP_VEL   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_ERR   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_PMUL  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_IMUL  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_WMUL  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ISAT  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SUM   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_CMD   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LIMIT = 4'd8;

  typedef struct packed {
    logic signed [15:0] desired_velocity;
    logic signed [15:0] encoder_count;
    logic               run_enable;
    logic               clear_integrator;
  } pivl_in_t;

  typedef struct packed {
    logic signed [8:0] drive_command;
    logic [7:0]        forward_duty;
    logic [7:0]        reverse_duty;
    logic              bridge_enable;
    logic              saturated;
  } pivl_out_t;

  typedef enum logic [1:0] {
    MUL_VEL,
    MUL_P,
    MUL_I,
    MUL_W
  } mul_sel_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ERR,
    OP_PLOAD,
    OP_IADD,
    OP_ISAT,
    OP_SUM,
    OP_CMD,
    OP_LIMIT
  } alu_op_e;

  typedef struct packed {
    mul_sel_e          mul_sel;
    logic              mul_en;
    alu_op_e           op;
    logic              jmp_stop;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctrl_t;

  // Control store. The multiplier result lands in the product register, and
  // the step after each issuing step consumes that product.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{mul_sel: MUL_VEL, mul_en: 1'b0, op: OP_NONE, jmp_stop: 1'b0,
          target: STEP_VEL, last: 1'b0};
    case (step)
      STEP_VEL: begin
        c.mul_en   = 1'b1;
        c.jmp_stop = 1'b1;
        c.target   = STEP_LIMIT;
      end
      STEP_ERR: begin
        c.op = OP_ERR;
      end
      STEP_PMUL: begin
        c.mul_sel = MUL_P;
        c.mul_en  = 1'b1;
      end
      STEP_IMUL: begin
        c.mul_sel = MUL_I;
        c.mul_en  = 1'b1;
        c.op      = OP_PLOAD;
      end
      STEP_WMUL: begin
        c.mul_sel = MUL_W;
        c.mul_en  = 1'b1;
        c.op      = OP_IADD;
      end
      STEP_ISAT: begin
        c.op = OP_ISAT;
      end
      STEP_SUM: begin
        c.op = OP_SUM;
      end
      STEP_CMD: begin
        c.op = OP_CMD;
      end
      STEP_LIMIT: begin
        c.op   = OP_LIMIT;
        c.last = 1'b1;
      end
      default: begin
        c.last = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- design/pivl_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
interface pivl_in_if;
  logic               valid;
  logic               ready;
  pivl_pkg::pivl_in_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface pivl_out_if;
  logic                valid;
  logic                ready;
  pivl_pkg::pivl_out_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- design/pi_velocity_loop_antiwindup.sv -----
// PI velocity loop with back-calculation anti-windup, microcoded datapath.
//
// One control tick is one input beat and gives one result beat. A beat with
// run on runs all nine microcode steps after acceptance, and its result
// lands in the output register at the last step. The steps are set by four
// products issued one per step to the single shared 25x17 multiplier and
// the wide integrator and command adds that follow them. With run off the
// program jumps straight to its last step. The next beat is taken as soon
// as the program has finished, while the previous result may still wait in
// the output register; the last step only stalls when that register is
// still full. Gains and limits sit on an APB-style port at byte address 4*i.
module pi_velocity_loop_antiwindup #(
  parameter int unsigned INTEGRATOR_WIDTH = pivl_pkg::INTEGRATOR_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pivl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  pivl_in_if.sink                     in_i,
  pivl_out_if.source                  out_o
);

  localparam int unsigned PW    = pivl_pkg::PROD_W;
  localparam int unsigned SUM_W =
    (INTEGRATOR_WIDTH > PW ? INTEGRATOR_WIDTH : PW) + 1;
  localparam int unsigned CMD_W = SUM_W - pivl_pkg::FRAC_W;
  localparam logic [INTEGRATOR_WIDTH-1:0] INT_MAX =
    {1'b0, {(INTEGRATOR_WIDTH-1){1'b1}}};
  localparam logic [INTEGRATOR_WIDTH-1:0] INT_MIN =
    {1'b1, {(INTEGRATOR_WIDTH-1){1'b0}}};
  localparam logic [8:0] LOWER_OUT_OF_RANGE = 9'h100;

  // Configuration registers.
  logic [23:0] pgain_q;
  logic [15:0] igain_q;
  logic [15:0] wgain_q;
  logic [15:0] vscale_q;
  logic [7:0]  upper_q;
  logic [8:0]  lower_q;

  // Sequencer.
  logic                          busy_q;
  logic [pivl_pkg::STEP_W-1:0]   step_q;
  pivl_pkg::ctrl_t               ctrl;
  logic                          stall;
  logic                          in_accept;
  logic                          cfg_write;

  // Datapath.
  logic signed [15:0]                 desired_q;
  logic signed [15:0]                 count_q;
  logic                               run_q;
  logic signed [PW-1:0]               prod_q;
  logic signed [PW-1:0]               pterm_q;
  logic signed [16:0]                 err_q;
  logic signed [SUM_W-1:0]            acc_q;
  logic signed [CMD_W-1:0]            cmd_q;
  logic signed [INTEGRATOR_WIDTH-1:0] integ_q;
  logic signed [15:0]                 excess_q;
  pivl_pkg::pivl_out_t                out_q;
  logic                               out_valid_q;

  logic signed [pivl_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pivl_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]                mul_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pgain_q  <= pivl_pkg::PGAIN_RST;
      igain_q  <= pivl_pkg::IGAIN_RST;
      wgain_q  <= pivl_pkg::WGAIN_RST;
      vscale_q <= pivl_pkg::VSCALE_RST;
      upper_q  <= pivl_pkg::UPPER_RST;
      lower_q  <= pivl_pkg::LOWER_RST;
    end else if (cfg_write) begin
      case (paddr[4:2])
        pivl_pkg::REG_PGAIN:  pgain_q  <= pwdata[23:0];
        pivl_pkg::REG_IGAIN:  igain_q  <= pwdata[15:0];
        pivl_pkg::REG_WGAIN:  wgain_q  <= pwdata[15:0];
        pivl_pkg::REG_VSCALE: vscale_q <= pwdata[15:0];
        pivl_pkg::REG_UPPER:  upper_q  <= pwdata[7:0];
        pivl_pkg::REG_LOWER:  lower_q  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:2])
      pivl_pkg::REG_PGAIN:  prdata = {8'b0, pgain_q};
      pivl_pkg::REG_IGAIN:  prdata = {16'b0, igain_q};
      pivl_pkg::REG_WGAIN:  prdata = {16'b0, wgain_q};
      pivl_pkg::REG_VSCALE: prdata = {16'b0, vscale_q};
      pivl_pkg::REG_UPPER:  prdata = {24'b0, upper_q};
      pivl_pkg::REG_LOWER:  prdata = {23'b0, lower_q};
      default:              prdata = '0;
    endcase
  end

  assign ctrl      = pivl_pkg::ucode(step_q);
  assign stall     = ctrl.last && out_valid_q && !out_o.ready;
  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready    = !busy_q;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Shared multiplier operand selection.
  always_comb begin
    case (ctrl.mul_sel)
      pivl_pkg::MUL_VEL: begin
        mul_a = signed'({9'b0, vscale_q});
        mul_b = 17'(count_q);
      end
      pivl_pkg::MUL_P: begin
        mul_a = signed'({1'b0, pgain_q});
        mul_b = err_q;
      end
      pivl_pkg::MUL_I: begin
        mul_a = signed'({9'b0, igain_q});
        mul_b = err_q;
      end
      pivl_pkg::MUL_W: begin
        mul_a = signed'({9'b0, wgain_q});
        mul_b = 17'(excess_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Measured velocity: divide by 16 toward zero, saturate to Q8.8.
  logic signed [PW-1:0] vel_bias;
  logic signed [PW-1:0] vel_div;
  logic signed [15:0]   meas;
  logic signed [16:0]   err_d;

  assign vel_bias = prod_q + signed'({{(PW-4){1'b0}}, {4{prod_q[PW-1]}}});
  assign vel_div  = vel_bias >>> 4;

  always_comb begin
    if (&vel_div[PW-1:15] || ~|vel_div[PW-1:15]) begin
      meas = vel_div[15:0];
    end else if (vel_div[PW-1]) begin
      meas = 16'sh8000;
    end else begin
      meas = 16'sh7FFF;
    end
  end

  assign err_d = 17'(desired_q) - 17'(meas);

  // Integrator update and saturation. The windup product carries a factor
  // of 256 to line up with the integrator's fraction.
  logic signed [SUM_W-1:0]            iadd_d;
  logic signed [SUM_W-1:0]            isum;
  logic signed [INTEGRATOR_WIDTH-1:0] integ_sat;
  logic signed [SUM_W-1:0]            sum_d;
  logic signed [SUM_W-1:0]            cmd_bias;

  assign iadd_d = SUM_W'(integ_q) + SUM_W'(prod_q);
  assign isum   = acc_q + (SUM_W'(prod_q) <<< 8);

  always_comb begin
    if (&isum[SUM_W-1:INTEGRATOR_WIDTH-1] || ~|isum[SUM_W-1:INTEGRATOR_WIDTH-1]) begin
      integ_sat = isum[INTEGRATOR_WIDTH-1:0];
    end else if (isum[SUM_W-1]) begin
      integ_sat = INT_MIN;
    end else begin
      integ_sat = INT_MAX;
    end
  end

  assign sum_d    = SUM_W'(integ_q) + SUM_W'(pterm_q);
  // Biasing a negative sum by one below the scale truncates toward zero.
  assign cmd_bias = acc_q + signed'({{(SUM_W-pivl_pkg::FRAC_W){1'b0}},
                                     {pivl_pkg::FRAC_W{acc_q[SUM_W-1]}}});

  // Limits, windup excess and the bridge split.
  logic signed [8:0]       lo_eff;
  logic signed [CMD_W-1:0] hi_c;
  logic signed [CMD_W-1:0] lo_c;
  logic                    ge_hi;
  logic                    le_lo;
  logic signed [CMD_W:0]   diff;
  logic signed [15:0]      excess_d;
  logic signed [8:0]       lim_cmd;
  logic signed [8:0]       fin_cmd;
  logic signed [8:0]       neg_cmd;
  pivl_pkg::pivl_out_t     out_d;

  assign lo_eff = (lower_q == LOWER_OUT_OF_RANGE) ? -9'sd255 : lower_q;
  assign hi_c   = CMD_W'(signed'({1'b0, upper_q}));
  assign lo_c   = CMD_W'(lo_eff);
  assign ge_hi  = cmd_q >= hi_c;
  assign le_lo  = cmd_q <= lo_c;
  assign diff   = ge_hi ? ((CMD_W+1)'(hi_c) - (CMD_W+1)'(cmd_q))
                        : ((CMD_W+1)'(lo_c) - (CMD_W+1)'(cmd_q));

  always_comb begin
    if (!(ge_hi || le_lo)) begin
      excess_d = '0;
    end else if (&diff[CMD_W:15] || ~|diff[CMD_W:15]) begin
      excess_d = diff[15:0];
    end else if (diff[CMD_W]) begin
      excess_d = 16'sh8000;
    end else begin
      excess_d = 16'sh7FFF;
    end
  end

  always_comb begin
    if (ge_hi) begin
      lim_cmd = signed'({1'b0, upper_q});
    end else if (le_lo) begin
      lim_cmd = lo_eff;
    end else begin
      lim_cmd = cmd_q[8:0];
    end
  end

  assign fin_cmd = run_q ? lim_cmd : '0;
  assign neg_cmd = -fin_cmd;

  always_comb begin
    out_d.drive_command = fin_cmd;
    out_d.forward_duty  = (!fin_cmd[8] && fin_cmd != 9'sd0) ? fin_cmd[7:0] : 8'd0;
    out_d.reverse_duty  = fin_cmd[8] ? neg_cmd[7:0] : 8'd0;
    out_d.bridge_enable = fin_cmd != 9'sd0;
    out_d.saturated     = run_q && (ge_hi || le_lo);
  end

  // Sequencer and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= pivl_pkg::STEP_VEL;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      excess_q    <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept) begin
        busy_q <= 1'b1;
        step_q <= pivl_pkg::STEP_VEL;
        if (in_i.payload.clear_integrator) begin
          integ_q  <= '0;
          excess_q <= '0;
        end
      end else if (busy_q && !stall) begin
        if (ctrl.last) begin
          busy_q <= 1'b0;
        end else if (ctrl.jmp_stop && !run_q) begin
          step_q <= ctrl.target;
        end else begin
          step_q <= step_q + 1'b1;
        end
        if (ctrl.op == pivl_pkg::OP_ISAT) begin
          integ_q <= integ_sat;
        end
        if (ctrl.op == pivl_pkg::OP_LIMIT) begin
          out_valid_q <= 1'b1;
          if (run_q) begin
            excess_q <= excess_d;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      desired_q <= in_i.payload.desired_velocity;
      count_q   <= in_i.payload.encoder_count;
      run_q     <= in_i.payload.run_enable;
    end else if (busy_q && !stall) begin
      if (ctrl.mul_en) begin
        prod_q <= mul_p;
      end
      case (ctrl.op)
        pivl_pkg::OP_ERR:   err_q   <= err_d;
        pivl_pkg::OP_PLOAD: pterm_q <= prod_q;
        pivl_pkg::OP_IADD:  acc_q   <= iadd_d;
        pivl_pkg::OP_SUM:   acc_q   <= sum_d;
        pivl_pkg::OP_CMD:   cmd_q   <= cmd_bias[SUM_W-1:pivl_pkg::FRAC_W];
        pivl_pkg::OP_LIMIT: out_q   <= out_d;
        default: ;
      endcase
    end
  end

  // A new beat always starts the program at its first step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> busy_q && step_q == pivl_pkg::STEP_VEL)
    else $error("program did not start on an accepted beat");

  // A full result register holds the last step in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && ctrl.last && out_valid_q && !out_o.ready |=> busy_q && $stable(step_q))
    else $error("last step advanced over an unread result");

  // A result appears only from the last step of the program.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q) && $past(step_q) == pivl_pkg::STEP_LIMIT)
    else $error("result raised outside the last step");

  // With run off the program leaves the integrator untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !run_q |=> $stable(integ_q))
    else $error("integrator moved while run was off");

endmodule

// ----- tb/pi_velocity_loop_antiwindup_test.sv -----
// Self-checking testbench for the PI velocity loop with back-calculation anti-windup.
module pi_velocity_loop_antiwindup_test;

  localparam int          IW           = pivl_pkg::INTEGRATOR_WIDTH_DEF;
  localparam int          DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pivl_in_if  in_bus();
  pivl_out_if out_bus();

  pi_velocity_loop_antiwindup i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Register copies and loop state of the predictor.
  logic [23:0] kp;
  logic [15:0] ki_dt;
  logic [15:0] kb_dt;
  logic [15:0] count_scale;
  logic [7:0]  cmd_max;
  logic [8:0]  cmd_min;
  longint      integ_sum;
  longint      excess_cnt;

  pivl_pkg::pivl_out_t pending_drive[$];
  int                  mismatches;
  int unsigned         cycles;
  int                  idle_pct;
  int                  stall_pct;
  int                  holdoff_req;
  int                  holdoff_left;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic pivl_pkg::pivl_out_t predict_tick(pivl_pkg::pivl_in_t t);
    longint              measured;
    longint              err;
    longint              total;
    longint              cmd;
    longint              negcmd;
    longint              hi;
    longint              lo;
    longint              imax;
    logic                sat;
    pivl_pkg::pivl_out_t r;
    imax = (longint'(1) << (IW - 1)) - 1;
    hi   = longint'(cmd_max);
    lo   = longint'($signed(cmd_min));
    if (lo < -255) lo = -255;
    cmd = 0;
    sat = 1'b0;
    if (t.clear_integrator) begin
      integ_sum  = 0;
      excess_cnt = 0;
    end
    if (t.run_enable) begin
      measured = longint'($signed(t.encoder_count)) * longint'(count_scale) / 16;
      measured = clip(measured, -32768, 32767);
      err = longint'($signed(t.desired_velocity)) - measured;
      integ_sum = clip(integ_sum + longint'(ki_dt) * err + longint'(kb_dt) * excess_cnt * 256,
                       -imax - 1, imax);
      total = longint'(kp) * err + integ_sum;
      // Division of a signed operand truncates toward zero.
      cmd = total / longint'(1 << pivl_pkg::FRAC_W);
      if (cmd >= hi) begin
        excess_cnt = clip(hi - cmd, -32768, 32767);
        cmd = hi;
        sat = 1'b1;
      end else if (cmd <= lo) begin
        excess_cnt = clip(lo - cmd, -32768, 32767);
        cmd = lo;
        sat = 1'b1;
      end else begin
        excess_cnt = 0;
      end
    end
    negcmd          = -cmd;
    r.drive_command = cmd[8:0];
    r.forward_duty  = (cmd > 0) ? cmd[7:0] : 8'd0;
    r.reverse_duty  = (cmd < 0) ? negcmd[7:0] : 8'd0;
    r.bridge_enable = (cmd != 0);
    r.saturated     = sat;
    return r;
  endfunction

  function automatic pivl_pkg::pivl_in_t mk_tick(int desired, int count, bit run, bit clr);
    pivl_pkg::pivl_in_t t;
    t.desired_velocity = 16'(desired);
    t.encoder_count    = 16'(count);
    t.run_enable       = run;
    t.clear_integrator = clr;
    return t;
  endfunction

  // Mostly ticks that hold a setpoint with an encoder reading near it, so the
  // integrator winds up and unwinds; the rest are unconstrained bit patterns.
  function automatic pivl_pkg::pivl_in_t random_tick(longint setpoint);
    pivl_pkg::pivl_in_t t;
    longint             count;
    longint             span;
    if ($urandom_range(99) < 10) begin
      t.desired_velocity = 16'($urandom);
      t.encoder_count    = 16'($urandom);
      t.run_enable       = 1'($urandom);
      t.clear_integrator = 1'($urandom);
    end else begin
      case ($urandom_range(2))
        0:       span = 4;
        1:       span = 200;
        default: span = 4000;
      endcase
      count = longint'($urandom_range(2 * span)) - span;
      if (count_scale != 0) count += setpoint * 16 / longint'(count_scale);
      t.desired_velocity = 16'(setpoint);
      t.encoder_count    = 16'(clip(count, -32768, 32767));
      t.run_enable       = ($urandom_range(99) >= 4);
      t.clear_integrator = ($urandom_range(99) < 2);
    end
    return t;
  endfunction

  task automatic send_tick(pivl_pkg::pivl_in_t t);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.payload <= t;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    pending_drive.push_back(predict_tick(t));
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pivl_pkg::REG_PGAIN:  kp          = value[23:0];
      pivl_pkg::REG_IGAIN:  ki_dt       = value[15:0];
      pivl_pkg::REG_WGAIN:  kb_dt       = value[15:0];
      pivl_pkg::REG_VSCALE: count_scale = value[15:0];
      pivl_pkg::REG_UPPER:  cmd_max     = value[7:0];
      pivl_pkg::REG_LOWER:  cmd_min     = value[8:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [23:0] p, logic [15:0] i, logic [15:0] w,
                            logic [15:0] v, logic [7:0] hi, logic [8:0] lo);
    wait_drain();
    write_reg(pivl_pkg::REG_PGAIN, {8'd0, p});
    write_reg(pivl_pkg::REG_IGAIN, {16'd0, i});
    write_reg(pivl_pkg::REG_WGAIN, {16'd0, w});
    write_reg(pivl_pkg::REG_VSCALE, {16'd0, v});
    write_reg(pivl_pkg::REG_UPPER, {24'd0, hi});
    write_reg(pivl_pkg::REG_LOWER, {23'd0, lo});
  endtask

  task automatic rand_config();
    logic [23:0] p;
    logic [15:0] v;
    p = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(400000, 20000));
    v = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20000, 1000));
    set_config(p, 16'($urandom), 16'($urandom), v, 8'($urandom_range(255, 20)),
               9'(0 - int'($urandom_range(255, 20))));
  endtask

  task automatic random_batch(int n);
    longint setpoint;
    int     hold;
    hold = 0;
    setpoint = 0;
    for (int k = 0; k < n; k++) begin
      if (hold == 0) begin
        setpoint = longint'($signed(16'($urandom))) >>> $urandom_range(8, 0);
        hold = $urandom_range(60, 5);
      end
      hold--;
      send_tick(random_tick(setpoint));
      if ($urandom_range(199) == 0) wait_drain();
    end
  endtask

  task automatic test_run_off_and_clear();
    send_tick(mk_tick(5000, 0, 1, 0));
    send_tick(mk_tick(5000, 0, 1, 0));
    send_tick(mk_tick(5000, 100, 0, 0));
    send_tick(mk_tick(5000, 0, 1, 0));
    send_tick(mk_tick(-700, 30, 0, 1));
    send_tick(mk_tick(0, 0, 1, 0));
    send_tick(mk_tick(-3000, 0, 1, 0));
    send_tick(mk_tick(-3000, 0, 1, 1));
  endtask

  task automatic test_field_extremes();
    send_tick(mk_tick(32767, -32768, 1, 1));
    send_tick(mk_tick(32767, -32768, 1, 0));
    send_tick(mk_tick(-32768, 32767, 1, 1));
    send_tick(mk_tick(0, 32767, 1, 0));
    send_tick(mk_tick(0, -32768, 1, 0));
    send_tick(mk_tick(-32768, -32768, 1, 1));
    send_tick(mk_tick(32767, 32767, 1, 0));
    // Single counts check the truncation of the measured velocity.
    send_tick(mk_tick(0, 1, 1, 1));
    send_tick(mk_tick(0, -1, 1, 1));
  endtask

  task automatic test_limit_cases();
    idle_pct  = 35;
    stall_pct = 35;
    set_config(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 9'(-255));
    send_tick(mk_tick(32767, -32768, 1, 1));
    send_tick(mk_tick(-32768, 32767, 1, 1));
    send_tick(mk_tick(-32768, 32767, 1, 0));
    random_batch(50);
    // A lower limit of -256 acts as -255.
    set_config(pivl_pkg::PGAIN_RST, pivl_pkg::IGAIN_RST, pivl_pkg::WGAIN_RST,
               pivl_pkg::VSCALE_RST, 8'd255, 9'h100);
    send_tick(mk_tick(-32768, 32767, 1, 1));
    random_batch(50);
    idle_pct  = 69;
    stall_pct = 0;
    // Crossed limits: the upper test wins, and anything below the upper limit gets the lower one.
    set_config(pivl_pkg::PGAIN_RST, pivl_pkg::IGAIN_RST, pivl_pkg::WGAIN_RST,
               pivl_pkg::VSCALE_RST, 8'd10, 9'd50);
    send_tick(mk_tick(2000, 0, 1, 1));
    send_tick(mk_tick(-2000, 0, 1, 1));
    random_batch(50);
    idle_pct  = 0;
    stall_pct = 69;
    set_config(24'd0, 16'd0, 16'd0, 16'd0, 8'd0, 9'd0);
    random_batch(40);
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    set_config(pivl_pkg::PGAIN_RST, pivl_pkg::IGAIN_RST, pivl_pkg::WGAIN_RST,
               pivl_pkg::VSCALE_RST, pivl_pkg::UPPER_RST, pivl_pkg::LOWER_RST);
    holdoff_req = 300;
    random_batch(40);
    wait_drain();
    random_batch(20);
  endtask

  task automatic test_random_phases();
    idle_pct  = 0;
    stall_pct = 0;
    random_batch(280);
    rand_config();
    idle_pct = 69;
    random_batch(280);
    rand_config();
    idle_pct  = 0;
    stall_pct = 69;
    random_batch(280);
    rand_config();
    idle_pct  = 35;
    stall_pct = 35;
    random_batch(280);
  endtask

  always @(negedge clk_i) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req  = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_beats
    pivl_pkg::pivl_out_t want;
    pivl_pkg::pivl_out_t got;
    if (out_bus.valid && out_bus.ready) begin
      got = out_bus.payload;
      if (pending_drive.size() == 0) begin
        $error("result beat with no tick outstanding: drive_command %0d",
               $signed(got.drive_command));
        mismatches++;
      end else begin
        want = pending_drive.pop_front();
        check_field("drive_command", $signed(want.drive_command), $signed(got.drive_command));
        check_field("forward_duty", want.forward_duty, got.forward_duty);
        check_field("reverse_duty", want.reverse_duty, got.reverse_duty);
        check_field("bridge_enable", want.bridge_enable, got.bridge_enable);
        check_field("saturated", want.saturated, got.saturated);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("** pi_velocity_loop_antiwindup: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_bus.valid   = 1'b0;
    in_bus.payload = '0;
    out_bus.ready  = 1'b0;
    mismatches     = 0;
    cycles         = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    holdoff_req    = 0;
    holdoff_left   = 0;
    kp             = pivl_pkg::PGAIN_RST;
    ki_dt          = pivl_pkg::IGAIN_RST;
    kb_dt          = pivl_pkg::WGAIN_RST;
    count_scale    = pivl_pkg::VSCALE_RST;
    cmd_max        = pivl_pkg::UPPER_RST;
    cmd_min        = pivl_pkg::LOWER_RST;
    integ_sum      = 0;
    excess_cnt     = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_run_off_and_clear();
    test_field_extremes();
    test_limit_cases();
    test_backpressure();
    test_random_phases();

    wait_drain();
    if (mismatches == 0 && pending_drive.size() == 0) begin
      $display("** pi_velocity_loop_antiwindup: PASSED **");
    end else begin
      $display("** pi_velocity_loop_antiwindup: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pivl_pkg.sv
design/pivl_if.sv
design/pi_velocity_loop_antiwindup.sv
tb/pi_velocity_loop_antiwindup_test.sv
